// ----- sv/gha_pkg.sv -----
// Shared command and status codes for the generational handle allocator.
package gha_pkg;

    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_SIG = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GET_SIG = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

endpackage

// ----- sv/gha_req_if.sv -----
// Request channel of the handle allocator.
interface gha_req_if #(
    parameter int IW = 10,
    parameter int GW = 8,
    parameter int SW = 32
);
    logic                       valid;
    logic                       ready;
    logic [gha_pkg::CMD_W-1:0]  command;
    logic [IW-1:0]              entity_index;
    logic [GW-1:0]              entity_generation;
    logic [SW-1:0]              signature_value;
    logic [IW-1:0]              active_position;

    modport source (output valid, command, entity_index, entity_generation,
                    signature_value, active_position, input ready);
    modport sink   (input valid, command, entity_index, entity_generation,
                    signature_value, active_position, output ready);
endinterface

// ----- sv/gha_rsp_if.sv -----
// Response channel of the handle allocator.
interface gha_rsp_if #(
    parameter int IW = 10,
    parameter int GW = 8,
    parameter int SW = 32,
    parameter int CW = 11
);
    logic                       valid;
    logic                       ready;
    logic [gha_pkg::STAT_W-1:0] status;
    logic [IW-1:0]              result_index;
    logic [GW-1:0]              result_generation;
    logic [SW-1:0]              signature_out;
    logic                       handle_valid;
    logic [CW-1:0]              active_count;

    modport source (output valid, status, result_index, result_generation,
                    signature_out, handle_valid, active_count, input ready);
    modport sink   (input valid, status, result_index, result_generation,
                    signature_out, handle_valid, active_count, output ready);
endinterface

// ----- sv/generational_handle_allocator_top.sv -----
// Generational handle allocator: one request in, one response out, state in RAMs.
// A request goes through S_EXEC; a create that reuses a freed index also through S_CRT
// (the free queue read must come before the generation read of that slot).
// No new request is taken until the response of the last one is registered.
// Reset clears the state, counters and response valid only; never-used slots fail the
// check by the high-water mark and take generation zero on create: no clearing pass.
module generational_handle_allocator_top #(
    parameter int MAX_ENTITIES = 1024,
    parameter int GEN_BITS     = 8,
    parameter int SIG_BITS     = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gha_req_if.sink   i_req,
    gha_rsp_if.source o_rsp
);
    localparam int IW = $clog2(MAX_ENTITIES);
    localparam int CW = $clog2(MAX_ENTITIES + 1);
    localparam int GW = GEN_BITS;
    localparam int SW = SIG_BITS;
    localparam int AW = IW + GW;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_CRT} t_state;

    t_state r_state, n_state;
    logic [gha_pkg::CMD_W-1:0] r_cmd;
    logic [IW-1:0] r_idx, r_pos, r_slot, n_slot;
    logic [GW-1:0] r_gen;
    logic [SW-1:0] r_sig;
    logic [IW-1:0] r_head, n_head, r_tail, n_tail;
    logic [CW-1:0] r_fcnt, n_fcnt, r_hw, n_hw, r_live, n_live;

    logic                      r_ovalid, n_ovalid;
    logic [gha_pkg::STAT_W-1:0] r_ostat, n_ostat;
    logic [IW-1:0]             r_oidx, n_oidx;
    logic [GW-1:0]             r_ogen, n_ogen;
    logic [SW-1:0]             r_osig, n_osig;
    logic                      r_ohv, n_ohv;

    // RAM controls
    logic          acc, fin, hv;
    logic          gen_we, gen_re, sig_we, loc_we, act_we, fq_we;
    logic [IW-1:0] gen_wa, gen_ra, sig_wa, loc_wa, loc_wd, act_wa, act_ra, fq_wa;
    logic [GW-1:0] gen_wd, gen_rd;
    logic [SW-1:0] sig_wd, sig_rd;
    logic [AW-1:0] act_wd, act_rd;
    logic [IW-1:0] loc_rd, fq_rd;
    logic          c_do;
    logic [IW-1:0] c_slot;
    logic [GW-1:0] c_gen;

    assign acc = (r_state == S_IDLE) && i_req.valid;
    assign i_req.ready = (r_state == S_IDLE);
    assign fin = !r_ovalid || o_rsp.ready;
    assign hv  = (CW'(r_idx) < r_hw) && (gen_rd == r_gen);

    always_comb begin
        n_state = r_state;  n_slot = r_slot;
        n_head = r_head;    n_tail = r_tail;  n_fcnt = r_fcnt;
        n_hw = r_hw;        n_live = r_live;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_ostat = r_ostat;  n_oidx = r_oidx;  n_ogen = r_ogen;
        n_osig = r_osig;    n_ohv = r_ohv;
        gen_re = acc;  gen_ra = i_req.entity_index;
        act_ra = (i_req.command == gha_pkg::CMD_READ) ? i_req.active_position
                                                      : IW'(r_live - CW'(1));
        gen_we = 1'b0; gen_wa = r_idx; gen_wd = GW'(gen_rd + GW'(1));
        sig_we = 1'b0; sig_wa = r_idx; sig_wd = '0;
        loc_we = 1'b0; loc_wa = act_rd[AW-1:GW]; loc_wd = loc_rd;
        act_we = 1'b0; act_wa = loc_rd; act_wd = act_rd;
        fq_we  = 1'b0; fq_wa = r_tail;
        c_do = 1'b0; c_slot = r_hw[IW-1:0]; c_gen = '0;

        if (r_state == S_EXEC && r_cmd == gha_pkg::CMD_CREATE && r_fcnt != '0) begin
            // Freed index known now; fetch its generation next.
            gen_re = 1'b1;
            gen_ra = fq_rd;
            n_slot = fq_rd;
            n_state = S_CRT;
        end else if (r_state == S_EXEC && fin) begin
            n_state = S_IDLE;
            n_ovalid = 1'b1;
            n_ostat = gha_pkg::ST_OK;
            n_oidx = '0; n_ogen = '0; n_osig = '0; n_ohv = 1'b0;
            case (r_cmd)
                gha_pkg::CMD_CREATE: begin
                    if (r_hw != CW'(MAX_ENTITIES)) begin
                        c_do = 1'b1;
                        gen_we = 1'b1; gen_wa = c_slot; gen_wd = '0;
                        n_hw = r_hw + CW'(1);
                    end else begin
                        n_ostat = gha_pkg::ST_FULL;
                    end
                end
                gha_pkg::CMD_DESTROY: begin
                    if (hv) begin
                        gen_we = 1'b1;
                        act_we = 1'b1;
                        loc_we = 1'b1;
                        sig_we = 1'b1;
                        fq_we  = 1'b1;
                        n_tail = (r_tail == IW'(MAX_ENTITIES - 1)) ? '0 : r_tail + IW'(1);
                        n_fcnt = r_fcnt + CW'(1);
                        n_live = r_live - CW'(1);
                    end else begin
                        n_ostat = gha_pkg::ST_INVALID;
                    end
                end
                gha_pkg::CMD_CHECK: begin
                    n_ohv = hv;
                    if (!hv) n_ostat = gha_pkg::ST_INVALID;
                end
                gha_pkg::CMD_SET_SIG: begin
                    n_ohv = hv;
                    if (hv) begin
                        sig_we = 1'b1; sig_wd = r_sig;
                    end else begin
                        n_ostat = gha_pkg::ST_INVALID;
                    end
                end
                gha_pkg::CMD_GET_SIG: begin
                    n_ohv = hv;
                    if (hv) n_osig = sig_rd;
                    else    n_ostat = gha_pkg::ST_INVALID;
                end
                gha_pkg::CMD_READ: begin
                    if (CW'(r_pos) < r_live) begin
                        n_ohv = 1'b1;
                        n_oidx = act_rd[AW-1:GW];
                        n_ogen = act_rd[GW-1:0];
                    end else begin
                        n_ostat = gha_pkg::ST_INVALID;
                    end
                end
                default: n_ostat = gha_pkg::ST_INVALID;
            endcase
        end else if (r_state == S_CRT && fin) begin
            n_state = S_IDLE;
            n_ovalid = 1'b1;
            n_ostat = gha_pkg::ST_OK;
            n_osig = '0;
            c_do = 1'b1;
            c_slot = r_slot;
            c_gen = gen_rd;
            n_head = (r_head == IW'(MAX_ENTITIES - 1)) ? '0 : r_head + IW'(1);
            n_fcnt = r_fcnt - CW'(1);
        end else if (acc) begin
            n_state = S_EXEC;
        end

        if (c_do) begin
            sig_we = 1'b1; sig_wa = c_slot; sig_wd = '0;
            act_we = 1'b1; act_wa = r_live[IW-1:0]; act_wd = {c_slot, c_gen};
            loc_we = 1'b1; loc_wa = c_slot; loc_wd = r_live[IW-1:0];
            n_live = r_live + CW'(1);
            n_ohv = 1'b1; n_oidx = c_slot; n_ogen = c_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0; r_tail <= '0; r_fcnt <= '0; r_hw <= '0; r_live <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head; r_tail <= n_tail; r_fcnt <= n_fcnt;
            r_hw <= n_hw; r_live <= n_live;
            r_ovalid <= n_ovalid;
        end
        if (acc) begin
            r_cmd <= i_req.command;
            r_idx <= i_req.entity_index;
            r_gen <= i_req.entity_generation;
            r_sig <= i_req.signature_value;
            r_pos <= i_req.active_position;
        end
        r_slot <= n_slot;
        r_ostat <= n_ostat; r_oidx <= n_oidx; r_ogen <= n_ogen;
        r_osig <= n_osig;   r_ohv <= n_ohv;
    end

    gha_ram #(.W(GW), .D(MAX_ENTITIES)) u_gen (
        .i_clk(i_clk), .i_we(gen_we), .i_waddr(gen_wa), .i_wdata(gen_wd),
        .i_re(gen_re), .i_raddr(gen_ra), .o_rdata(gen_rd));
    gha_ram #(.W(SW), .D(MAX_ENTITIES)) u_sig (
        .i_clk(i_clk), .i_we(sig_we), .i_waddr(sig_wa), .i_wdata(sig_wd),
        .i_re(acc), .i_raddr(i_req.entity_index), .o_rdata(sig_rd));
    gha_ram #(.W(IW), .D(MAX_ENTITIES)) u_loc (
        .i_clk(i_clk), .i_we(loc_we), .i_waddr(loc_wa), .i_wdata(loc_wd),
        .i_re(acc), .i_raddr(i_req.entity_index), .o_rdata(loc_rd));
    gha_ram #(.W(AW), .D(MAX_ENTITIES)) u_act (
        .i_clk(i_clk), .i_we(act_we), .i_waddr(act_wa), .i_wdata(act_wd),
        .i_re(acc), .i_raddr(act_ra), .o_rdata(act_rd));
    gha_ram #(.W(IW), .D(MAX_ENTITIES)) u_fq (
        .i_clk(i_clk), .i_we(fq_we), .i_waddr(fq_wa), .i_wdata(r_idx),
        .i_re(acc), .i_raddr(r_head), .o_rdata(fq_rd));

    assign o_rsp.valid             = r_ovalid;
    assign o_rsp.status            = r_ostat;
    assign o_rsp.result_index      = r_oidx;
    assign o_rsp.result_generation = r_ogen;
    assign o_rsp.signature_out     = r_osig;
    assign o_rsp.handle_valid      = r_ohv;
    assign o_rsp.active_count      = r_live;
endmodule

// ----- sv/gha_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module gha_ram #(
    parameter int W = 8,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
